// File: src/usr_pkg.sv
package usr_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned STEP_W    = 7;
  localparam int unsigned DIST_W    = 10;
  localparam int unsigned THR_W     = 8;
  localparam int unsigned TICKS_W   = 10;
  localparam int unsigned PULSE_W   = 16;
  localparam int unsigned ANGLE_W   = 8;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned DIST_OUT_W = 16;
  localparam int unsigned RUN_W     = 8;

  localparam logic [ANGLE_W-1:0]    ANGLE_MAX    = 8'd180;
  localparam logic [DIST_OUT_W-1:0] INVALID_DIST = 16'hFFFF;
  localparam logic [RUN_W-1:0]      RUN_MAX      = 8'hFF;

  localparam logic [STEP_W-1:0]  STEP_RST      = 7'd10;
  localparam logic [DIST_W-1:0]  MAX_DIST_RST  = 10'd400;
  localparam logic [THR_W-1:0]   FAULT_THR_RST = 8'd10;
  localparam logic [TICKS_W-1:0] TICKS_RST     = 10'd58;
  localparam logic [PULSE_W-1:0] PULSE_MIN_RST = 16'd620;
  localparam logic [PULSE_W-1:0] PULSE_MAX_RST = 16'd2420;

  localparam int unsigned MUL_STEPS   = ANGLE_W;
  localparam int unsigned PROD_W      = 24;
  localparam int unsigned SERVO_STEPS = MUL_STEPS + PROD_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP      = 3'd0,
    CFG_MAX_DIST  = 3'd1,
    CFG_FAULT_THR = 3'd2,
    CFG_TICKS     = 3'd3,
    CFG_PULSE_MIN = 3'd4,
    CFG_PULSE_MAX = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic               kind;
    logic [STAMP_W-1:0] edge_time;
  } in_item_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]    scan_angle;
    logic [DIST_OUT_W-1:0] distance_cm;
    logic                  sensor_fault;
    logic [PULSE_W-1:0]    servo_pulse_us;
  } out_item_t;

endpackage

// File: src/usr_if.sv
interface usr_in_if;
  logic              valid;
  logic              ready;
  usr_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface usr_out_if;
  logic               valid;
  logic               ready;
  usr_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/ultrasonic_sweep_ranger_unit.sv
// Ultrasonic echo ranger with a ping-pong servo sweep. A rising capture edge is
// accepted and gives no transaction on the output. A falling edge or an echo
// timeout completes a ping; its result is worked out under one shared step
// counter that drives a bit-serial restoring divider for the distance (TIME_BITS
// steps) alongside a bit-serial multiply (8 steps) and divide by 180 (24 steps)
// for the servo pulse. A new item is taken once the result has moved into the
// output register, so a held result stalls the input only while a second ping
// has also finished.
module ultrasonic_sweep_ranger_unit #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [usr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [usr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  usr_in_if.sink                         in_i,
  usr_out_if.source                      out_o
);
  import usr_pkg::*;

  localparam int unsigned STAMP_USE  = (TIME_BITS < STAMP_W) ? TIME_BITS : STAMP_W;
  localparam int unsigned RUN_CYCLES = (TIME_BITS > SERVO_STEPS) ? TIME_BITS : SERVO_STEPS;
  localparam int unsigned CNT_W      = $clog2(RUN_CYCLES + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RUN_CYCLES - 1);
  localparam logic [CNT_W-1:0] DIV_END  = CNT_W'(TIME_BITS);
  localparam logic [CNT_W-1:0] MUL_END  = CNT_W'(MUL_STEPS);
  localparam logic [CNT_W-1:0] SDIV_END = CNT_W'(SERVO_STEPS);

  logic [STEP_W-1:0]  step_q;
  logic [DIST_W-1:0]  max_dist_q;
  logic [THR_W-1:0]   fault_thr_q;
  logic [TICKS_W-1:0] ticks_q;
  logic [PULSE_W-1:0] pulse_min_q;
  logic [PULSE_W-1:0] pulse_max_q;

  state_e state_q, state_d;

  logic                 awaiting_q;
  logic [TIME_BITS-1:0] rise_q;
  logic [ANGLE_W-1:0]   angle_q, angle_d;
  logic                 down_q, down_d;
  logic [RUN_W-1:0]     run_q, run_d;
  logic                 fault_q, fault_d;

  logic [CNT_W-1:0]     cnt_q;
  logic                 timeout_q;
  logic [TIME_BITS-1:0] dq_q, dq_d;
  logic [TICKS_W-1:0]   rem_q, rem_d;
  logic [PROD_W-1:0]    acc_q, acc_d;
  logic [ANGLE_W-1:0]   srem_q, srem_d;
  logic [ANGLE_W-1:0]   ang_sh_q;
  logic [PULSE_W-1:0]   span_q;
  logic [ANGLE_W-1:0]   taken_q;

  logic      out_valid_q;
  out_item_t out_data_q, out_data_d;

  logic in_ready;
  logic run_en;
  logic load_out;
  logic in_fire;
  logic start;

  logic [TIME_BITS-1:0] stamp;
  logic [TIME_BITS-1:0] width;

  logic signed [ANGLE_W+1:0] nx;

  logic [TICKS_W:0] dtrial;
  logic             dge;
  logic [TICKS_W:0] ddiff;
  logic [ANGLE_W:0] strial;
  logic             sge;
  logic [ANGLE_W:0] sdiff;

  logic                  over;
  logic                  invalid;
  logic [RUN_W-1:0]      run_inc;

  assign in_fire = in_i.valid && in_ready;
  assign start   = in_fire && (in_i.data.kind || awaiting_q);
  assign stamp   = TIME_BITS'(in_i.data.edge_time[STAMP_USE-1:0]);
  assign width   = stamp - rise_q;

  assign in_i.ready   = in_ready;
  assign out_o.valid  = out_valid_q;
  assign out_o.data   = out_data_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (cnt_q == CNT_LAST) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    run_en   = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      S_IDLE:   in_ready = 1'b1;
      S_RUN:    run_en   = 1'b1;
      S_FINISH: load_out = !out_valid_q || out_o.ready;
      default: begin
      end
    endcase
  end

  always_comb begin
    nx = down_q ? ($signed({2'b00, angle_q}) - $signed({3'b000, step_q}))
                : ($signed({2'b00, angle_q}) + $signed({3'b000, step_q}));
    angle_d = angle_q;
    down_d  = down_q;
    if (nx >= $signed({2'b00, ANGLE_MAX})) begin
      angle_d = ANGLE_MAX;
      down_d  = 1'b1;
    end else if (nx <= 0) begin
      angle_d = '0;
      down_d  = 1'b0;
    end else begin
      angle_d = nx[ANGLE_W-1:0];
    end
  end

  always_comb begin
    dtrial = {rem_q, dq_q[TIME_BITS-1]};
    ddiff  = dtrial - {1'b0, ticks_q};
    dge    = dtrial >= {1'b0, ticks_q};
    rem_d  = dge ? ddiff[TICKS_W-1:0] : dtrial[TICKS_W-1:0];
    dq_d   = {dq_q[TIME_BITS-2:0], dge};
  end

  always_comb begin
    strial = {srem_q, acc_q[PROD_W-1]};
    sdiff  = strial - {1'b0, ANGLE_MAX};
    sge    = strial >= {1'b0, ANGLE_MAX};
    srem_d = srem_q;
    acc_d  = acc_q;
    if (cnt_q < MUL_END) begin
      acc_d = {acc_q[PROD_W-2:0], 1'b0} + (ang_sh_q[ANGLE_W-1] ? PROD_W'(span_q) : '0);
    end else if (cnt_q < SDIV_END) begin
      srem_d = sge ? sdiff[ANGLE_W-1:0] : strial[ANGLE_W-1:0];
      acc_d  = {acc_q[PROD_W-2:0], sge};
    end
  end

  always_comb begin
    over    = (|dq_q[TIME_BITS-1:DIST_W]) || (dq_q[DIST_W-1:0] > max_dist_q);
    invalid = timeout_q || over;
    run_inc = (run_q == RUN_MAX) ? RUN_MAX : run_q + 1'b1;
    run_d   = invalid ? run_inc : '0;
    fault_d = invalid ? (fault_q || (run_inc >= fault_thr_q)) : 1'b0;
    out_data_d.scan_angle     = taken_q;
    out_data_d.distance_cm    = invalid ? INVALID_DIST : dq_q[DIST_OUT_W-1:0];
    out_data_d.sensor_fault   = fault_d;
    out_data_d.servo_pulse_us = pulse_min_q + acc_q[PULSE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_RST;
      max_dist_q  <= MAX_DIST_RST;
      fault_thr_q <= FAULT_THR_RST;
      ticks_q     <= TICKS_RST;
      pulse_min_q <= PULSE_MIN_RST;
      pulse_max_q <= PULSE_MAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STEP:      step_q      <= cfg_wdata_i[STEP_W-1:0];
        CFG_MAX_DIST:  max_dist_q  <= cfg_wdata_i[DIST_W-1:0];
        CFG_FAULT_THR: fault_thr_q <= cfg_wdata_i[THR_W-1:0];
        CFG_TICKS:     ticks_q     <= cfg_wdata_i[TICKS_W-1:0];
        CFG_PULSE_MIN: pulse_min_q <= cfg_wdata_i[PULSE_W-1:0];
        CFG_PULSE_MAX: pulse_max_q <= cfg_wdata_i[PULSE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      awaiting_q  <= 1'b0;
      rise_q      <= '0;
      angle_q     <= '0;
      down_q      <= 1'b0;
      run_q       <= '0;
      fault_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        if (start) begin
          awaiting_q <= 1'b0;
          angle_q    <= angle_d;
          down_q     <= down_d;
        end else begin
          awaiting_q <= 1'b1;
          rise_q     <= stamp;
        end
      end
      if (start) begin
        cnt_q <= '0;
      end else if (run_en) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (load_out) begin
        run_q       <= run_d;
        fault_q     <= fault_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      timeout_q <= in_i.data.kind;
      taken_q   <= angle_q;
      dq_q      <= width;
      rem_q     <= '0;
      acc_q     <= '0;
      srem_q    <= '0;
      ang_sh_q  <= angle_d;
      span_q    <= (pulse_max_q > pulse_min_q) ? (pulse_max_q - pulse_min_q) : '0;
    end else if (run_en) begin
      if (cnt_q < DIV_END) begin
        dq_q  <= dq_d;
        rem_q <= rem_d;
      end
      acc_q  <= acc_d;
      srem_q <= srem_d;
      if (cnt_q < MUL_END) begin
        ang_sh_q <= {ang_sh_q[ANGLE_W-2:0], 1'b0};
      end
    end
    if (load_out) begin
      out_data_q <= out_data_d;
    end
  end

`ifndef ASSERT_OFF
  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> state_q == S_RUN)
    else $error("completed ping did not start the step sequence");

  a_out_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FINISH))
    else $error("output transaction appeared without a finished ping");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    angle_q <= ANGLE_MAX)
    else $error("scan angle left its range");

  a_fault_has_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_q |-> run_q != '0)
    else $error("sensor fault raised without invalid pings");
`endif

endmodule
